FILE: hdl/sparse_polynomial_evaluator_defines.svh
// Assertion macros shared by the checker files of the evaluator.
// Each macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef SPARSE_POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define SPARSE_POLYNOMIAL_EVALUATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/spe_pkg.sv
`timescale 1ns / 1ps

package spe_pkg;

	// Table size and exponent limit.
	localparam int MAX_TERMS  = 16;
	localparam int MAX_EXP    = 255;
	localparam int TERM_IDX_W = $clog2(MAX_TERMS);
	localparam int COUNT_W    = $clog2(MAX_TERMS + 1);

	// Field widths.
	localparam int OP_W    = 2;
	localparam int COEFF_W = 32;
	localparam int EXP_W   = 8;
	localparam int POINT_W = 32;
	localparam int VALUE_W = 64;
	localparam int TERM_W  = COEFF_W + EXP_W;

	// Table of x raised to successive powers of two, one entry per exponent bit.
	localparam int POW_N     = EXP_W;
	localparam int POW_IDX_W = $clog2(POW_N);

	// Stream widths.
	localparam int S_TUSER_W = OP_W;
	localparam int IN_BITS   = COEFF_W + EXP_W + POINT_W;
	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = VALUE_W + 1 + COUNT_W + EXP_W;
	localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Item kinds.
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_CLEAR  = 2'd0;
	localparam op_t OP_APPEND = 2'd1;
	localparam op_t OP_EVAL   = 2'd2;
	localparam op_t OP_DERIV  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic init;
		logic table_clear;
		logic table_append;
		logic mul_start;
		logic mul_sq;
		logic sq_write;
		logic term_load;
		logic bit_step;
		logic acc_from_mul;
		logic sum_add;
		logic out_load;
	} spe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic mul_done;
		logic more_sq;
		logic empty;
		logic ebits_zero;
		logic ebits_lsb;
		logic last_term;
	} spe_sts_t;

endpackage

FILE: hdl/sparse_polynomial_evaluator.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields (low bit first)
// s_*      in   tuser: op[1:0]; tdata: term_coeff[31:0], term_exp[39:32], eval_point[71:40]
// m_*      out  tdata: value[63:0], status[64], num_terms[69:65], degree[77:70], zero pad
//
// One item at a time: clear, append and an empty evaluation go from the execute state straight to done.
// An evaluation first squares x once per bit of the degree above the lowest, then, for each term,
// loads it and multiplies its running product by the power of x for each set exponent bit;
// every 64-bit product runs three passes through one shared 32x32 multiplier.
// arst_n clears the term table's count and degree; the result register holds one finished
// beat, so the next item is taken while a result waits and stalls only at its own end.
module sparse_polynomial_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// op[1:0]
	input  logic [spe_pkg::S_TUSER_W-1:0] s_tuser,
	// term_coeff[31:0], term_exp[39:32], eval_point[71:40]
	input  logic [spe_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// value[63:0], status[64], num_terms[69:65], degree[77:70], zeros above
	output logic [spe_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int EXP_LO   = spe_pkg::COEFF_W;
	localparam int POINT_LO = spe_pkg::COEFF_W + spe_pkg::EXP_W;

	spe_pkg::spe_cmd_t           cmd;
	spe_pkg::spe_sts_t           sts;
	logic [spe_pkg::VALUE_W-1:0] value;
	logic                        status;
	logic [spe_pkg::COUNT_W-1:0] num_terms;
	logic [spe_pkg::EXP_W-1:0]   degree;

	spe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	spe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (s_tuser[spe_pkg::OP_W-1:0]),
		.term_coeff(s_tdata[spe_pkg::COEFF_W-1:0]),
		.term_exp  (s_tdata[POINT_LO-1:EXP_LO]),
		.eval_point(s_tdata[spe_pkg::IN_BITS-1:POINT_LO]),
		.value     (value),
		.status    (status),
		.num_terms (num_terms),
		.degree    (degree)
	);

	// Pack the result beat.
	assign m_tdata = {(spe_pkg::M_TDATA_W - spe_pkg::OUT_BITS)'(0),
		degree, num_terms, status, value};

endmodule

FILE: hdl/spe_ram.sv
`timescale 1ns / 1ps

module spe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/spe_mul.sv
`timescale 1ns / 1ps

module spe_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [spe_pkg::VALUE_W-1:0] a,
	input  logic [spe_pkg::VALUE_W-1:0] b,
	output logic                        done,
	output logic [spe_pkg::VALUE_W-1:0] p
);

	localparam int HALF_W = spe_pkg::VALUE_W / 2;

	// Partial products of the low word: lo*lo, then the two cross terms.
	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;

	logic [spe_pkg::VALUE_W-1:0] a_q;
	logic [spe_pkg::VALUE_W-1:0] b_q;
	logic [1:0]                  step_q;
	logic                        busy_q;
	logic                        pvld_s1;
	logic [1:0]                  pstep_s1;
	logic [spe_pkg::VALUE_W-1:0] prod_s1;
	logic [spe_pkg::VALUE_W-1:0] acc_q;
	logic                        done_q;
	logic [HALF_W-1:0]           opa;
	logic [HALF_W-1:0]           opb;
	logic [spe_pkg::VALUE_W-1:0] mult;

	// Operand selection for the shared 32x32 multiplier.
	always_comb begin
		case (step_q)
			STEP_LL: begin
				opa = a_q[HALF_W-1:0];
				opb = b_q[HALF_W-1:0];
			end
			STEP_LH: begin
				opa = a_q[HALF_W-1:0];
				opb = b_q[spe_pkg::VALUE_W-1:HALF_W];
			end
			default: begin
				opa = a_q[spe_pkg::VALUE_W-1:HALF_W];
				opb = b_q[HALF_W-1:0];
			end
		endcase
	end

	assign mult = {{HALF_W{1'b0}}, opa} * {{HALF_W{1'b0}}, opb};

	// Step sequencing and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= STEP_LL;
			pvld_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LL;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == STEP_HL) begin
					busy_q <= 1'b0;
				end
			end
			pvld_s1 <= busy_q;
			done_q  <= pvld_s1 && (pstep_s1 == STEP_HL);
		end
	end

	// Operand capture, product register and accumulation of the low word.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (busy_q) begin
			prod_s1  <= mult;
			pstep_s1 <= step_q;
		end
		if (pvld_s1) begin
			if (pstep_s1 == STEP_LL) begin
				acc_q <= prod_s1;
			end else begin
				acc_q <= acc_q + {prod_s1[HALF_W-1:0], {HALF_W{1'b0}}};
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

FILE: hdl/spe_dp.sv
`timescale 1ns / 1ps

module spe_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spe_pkg::spe_cmd_t           cmd,
	output spe_pkg::spe_sts_t           sts,
	input  spe_pkg::op_t                op,
	input  logic [spe_pkg::COEFF_W-1:0] term_coeff,
	input  logic [spe_pkg::EXP_W-1:0]   term_exp,
	input  logic [spe_pkg::POINT_W-1:0] eval_point,
	output logic [spe_pkg::VALUE_W-1:0] value,
	output logic                        status,
	output logic [spe_pkg::COUNT_W-1:0] num_terms,
	output logic [spe_pkg::EXP_W-1:0]   degree
);

	localparam int EC_W = spe_pkg::COEFF_W + spe_pkg::EXP_W + 1;

	// Captured item.
	spe_pkg::op_t                  op_q;
	logic [spe_pkg::COEFF_W-1:0]   coeff_q;
	logic [spe_pkg::EXP_W-1:0]     exp_q;

	// Table bookkeeping.
	logic [spe_pkg::COUNT_W-1:0]   term_count_q;
	logic [spe_pkg::EXP_W-1:0]     max_exp_q;
	logic                          full;

	// Evaluation state.
	logic [spe_pkg::VALUE_W-1:0]   pow_q [spe_pkg::POW_N];
	logic [spe_pkg::POW_IDX_W-1:0] k_q;
	logic [spe_pkg::POW_IDX_W-1:0] k_next;
	logic [spe_pkg::POW_IDX_W:0]   sq_shift;
	logic [spe_pkg::TERM_IDX_W-1:0] idx_q;
	logic [spe_pkg::EXP_W-1:0]     ebits_q;
	logic [spe_pkg::VALUE_W-1:0]   acc_q;
	logic [spe_pkg::VALUE_W-1:0]   sum_q;
	logic                          status_q;

	// Result register.
	logic [spe_pkg::VALUE_W-1:0]   out_value_q;
	logic                          out_status_q;
	logic [spe_pkg::COUNT_W-1:0]   out_count_q;
	logic [spe_pkg::EXP_W-1:0]     out_degree_q;

	// Term store and multiplier connections.
	logic [spe_pkg::EXP_W-1:0]     exp_sat;
	logic                          ram_we;
	logic [spe_pkg::TERM_W-1:0]    ram_rdata;
	logic [spe_pkg::COEFF_W-1:0]   rd_coeff;
	logic [spe_pkg::EXP_W-1:0]     rd_exp;
	logic signed [EC_W-1:0]        ec;
	logic [spe_pkg::VALUE_W-1:0]   term_acc;
	logic [spe_pkg::EXP_W-1:0]     term_ebits;
	logic [spe_pkg::VALUE_W-1:0]   mul_a;
	logic                          mul_done;
	logic [spe_pkg::VALUE_W-1:0]   mul_p;

	// Exponents beyond the limit are clamped before they are stored.
	assign exp_sat = (int'(term_exp) > spe_pkg::MAX_EXP) ?
		spe_pkg::EXP_W'(spe_pkg::MAX_EXP) : term_exp;

	assign full   = (term_count_q == spe_pkg::COUNT_W'(spe_pkg::MAX_TERMS));
	assign ram_we = cmd.table_append && !full;

	spe_ram #(
		.WIDTH(spe_pkg::TERM_W),
		.DEPTH(spe_pkg::MAX_TERMS)
	) u_term_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(term_count_q[spe_pkg::TERM_IDX_W-1:0]),
		.wdata({exp_q, coeff_q}),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_coeff = ram_rdata[spe_pkg::COEFF_W-1:0];
	assign rd_exp   = ram_rdata[spe_pkg::TERM_W-1:spe_pkg::COEFF_W];

	// Starting value and remaining exponent of one term.
	assign ec = EC_W'(signed'(rd_coeff)) * EC_W'(signed'({1'b0, rd_exp}));

	always_comb begin
		if (op_q == spe_pkg::OP_DERIV) begin
			if (rd_exp == '0) begin
				term_acc   = '0;
				term_ebits = '0;
			end else begin
				term_acc   = spe_pkg::VALUE_W'(ec);
				term_ebits = rd_exp - spe_pkg::EXP_W'(1);
			end
		end else begin
			term_acc   = spe_pkg::VALUE_W'(signed'(rd_coeff));
			term_ebits = rd_exp;
		end
	end

	// Squaring uses the current power twice; a term multiplies its running product.
	assign mul_a = cmd.mul_sq ? pow_q[k_q] : acc_q;

	spe_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (pow_q[k_q]),
		.done  (mul_done),
		.p     (mul_p)
	);

	assign k_next   = k_q + spe_pkg::POW_IDX_W'(1);
	assign sq_shift = {1'b0, k_q} + (spe_pkg::POW_IDX_W + 1)'(1);

	// Term count and degree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= '0;
			max_exp_q    <= '0;
		end else if (cmd.table_clear) begin
			term_count_q <= '0;
			max_exp_q    <= '0;
		end else if (ram_we) begin
			term_count_q <= term_count_q + spe_pkg::COUNT_W'(1);
			if (exp_q > max_exp_q) begin
				max_exp_q <= exp_q;
			end
		end
	end

	// Bit, term and exponent counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			idx_q   <= '0;
			ebits_q <= '0;
		end else begin
			if (cmd.capture) begin
				k_q <= '0;
			end else if (cmd.term_load) begin
				k_q     <= '0;
				ebits_q <= term_ebits;
			end else if (cmd.bit_step) begin
				k_q     <= k_next;
				ebits_q <= ebits_q >> 1;
			end else if (cmd.sq_write) begin
				k_q <= k_next;
			end
			if (cmd.init) begin
				idx_q <= '0;
			end else if (cmd.sum_add) begin
				idx_q <= idx_q + spe_pkg::TERM_IDX_W'(1);
			end
		end
	end

	// Item capture, power table, running products and result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			coeff_q  <= term_coeff;
			exp_q    <= exp_sat;
			pow_q[0] <= spe_pkg::VALUE_W'(signed'(eval_point));
		end else if (cmd.sq_write) begin
			pow_q[k_next] <= mul_p;
		end
		if (cmd.init) begin
			sum_q    <= '0;
			status_q <= (op_q == spe_pkg::OP_APPEND) && full;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + acc_q;
		end
		if (cmd.term_load) begin
			acc_q <= term_acc;
		end else if (cmd.acc_from_mul) begin
			acc_q <= mul_p;
		end
		if (cmd.out_load) begin
			out_value_q  <= sum_q;
			out_status_q <= status_q;
			out_count_q  <= term_count_q;
			out_degree_q <= max_exp_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.op         = op_q;
		sts.mul_done   = mul_done;
		sts.more_sq    = (max_exp_q >> sq_shift) != '0;
		sts.empty      = (term_count_q == '0);
		sts.ebits_zero = (ebits_q == '0);
		sts.ebits_lsb  = ebits_q[0];
		sts.last_term  = (spe_pkg::COUNT_W'(idx_q) + spe_pkg::COUNT_W'(1)) == term_count_q;
	end

	assign value     = out_value_q;
	assign status    = out_status_q;
	assign num_terms = out_count_q;
	assign degree    = out_degree_q;

endmodule

FILE: hdl/spe_ctrl.sv
`timescale 1ns / 1ps

module spe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output spe_pkg::spe_cmd_t cmd,
	input  spe_pkg::spe_sts_t sts
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_EXEC     = 4'd1;
	localparam logic [3:0] ST_SQ       = 4'd2;
	localparam logic [3:0] ST_SQ_WAIT  = 4'd3;
	localparam logic [3:0] ST_TERM_RD  = 4'd4;
	localparam logic [3:0] ST_TERM_LD  = 4'd5;
	localparam logic [3:0] ST_POW      = 4'd6;
	localparam logic [3:0] ST_POW_WAIT = 4'd7;
	localparam logic [3:0] ST_ADD      = 4'd8;
	localparam logic [3:0] ST_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	// The result register can take a new result once it is empty or being drained.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.init = 1'b1;
				if (sts.op == spe_pkg::OP_CLEAR) begin
					cmd.table_clear = 1'b1;
					state_d         = ST_DONE;
				end else if (sts.op == spe_pkg::OP_APPEND) begin
					cmd.table_append = 1'b1;
					state_d          = ST_DONE;
				end else if (sts.empty) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (sts.more_sq) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sq    = 1'b1;
					state_d       = ST_SQ_WAIT;
				end else begin
					state_d = ST_TERM_RD;
				end
			end
			ST_SQ_WAIT: begin
				if (sts.mul_done) begin
					cmd.sq_write = 1'b1;
					state_d      = ST_SQ;
				end
			end
			ST_TERM_RD: begin
				state_d = ST_TERM_LD;
			end
			ST_TERM_LD: begin
				cmd.term_load = 1'b1;
				state_d       = ST_POW;
			end
			ST_POW: begin
				if (sts.ebits_zero) begin
					state_d = ST_ADD;
				end else if (sts.ebits_lsb) begin
					cmd.mul_start = 1'b1;
					state_d       = ST_POW_WAIT;
				end else begin
					cmd.bit_step = 1'b1;
				end
			end
			ST_POW_WAIT: begin
				if (sts.mul_done) begin
					cmd.acc_from_mul = 1'b1;
					cmd.bit_step     = 1'b1;
					state_d          = ST_POW;
				end
			end
			ST_ADD: begin
				cmd.sum_add = 1'b1;
				state_d     = sts.last_term ? ST_DONE : ST_TERM_RD;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/spe_checker.sv
`timescale 1ns / 1ps
`include "sparse_polynomial_evaluator_defines.svh"

module spe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [spe_pkg::M_TDATA_W-1:0] m_tdata
);

	// A result beat that is not taken stays put.
	`SPE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// One item at a time: the input side closes right after a beat.
	`SPE_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")

	// A dropped append is only reported with a full table.
	`SPE_ASSERT_SAME(a_full_flag, m_tvalid && m_tdata[64], m_tdata[69:65] == 5'(spe_pkg::MAX_TERMS), "table-full flag without a full table")

	// The reported term count never exceeds the table size.
	`SPE_ASSERT_SAME(a_count_max, m_tvalid, m_tdata[69:65] <= 5'(spe_pkg::MAX_TERMS), "term count above table size")

	// An empty table has degree zero and evaluates to zero.
	`SPE_ASSERT_SAME(a_empty, m_tvalid && m_tdata[69:65] == 5'd0, m_tdata[77:70] == 8'd0 && m_tdata[63:0] == 64'd0, "empty table gave nonzero degree or value")

endmodule

bind sparse_polynomial_evaluator spe_checker u_spe_checker (.*);
